[sv/fscc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fscc_pkg
// Shared constants, register indexes, mode codes and types of the fan speed
// curve controller.
// ----------------------------------------------------------------------------
package fscc_pkg;

    // Number of curve points; points beyond the ten held in registers read as zero.
    localparam int CURVE_POINTS   = 10;
    localparam int POINTS_PER_REG = 5;
    localparam int TEMP_W         = 8;
    localparam int RPM_W          = 16;
    localparam int PCT_W          = 7;
    localparam int DUTY_W         = 8;
    localparam int STEP_SUM_W     = 10;

    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 40;
    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 16;

    typedef logic signed [DUTY_W-1:0] duty_t;
    typedef logic [PCT_W-1:0]         pct_t;
    typedef logic [TEMP_W-1:0]        temp_t;

    localparam duty_t AUTO_DUTY = -8'sd2;
    localparam pct_t  MAX_DUTY  = 7'd100;

    // Control mode codes.
    localparam logic [2:0] MODE_AUTO   = 3'd0;
    localparam logic [2:0] MODE_MAX    = 3'd1;
    localparam logic [2:0] MODE_STATIC = 3'd2;
    localparam logic [2:0] MODE_HOLD   = 3'd3;
    localparam logic [2:0] MODE_STEP   = 3'd4;
    localparam logic [2:0] MODE_CURVE  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STATIC_DUTY       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_PARAMS       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_TEMPS_LOW   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_TEMPS_HIGH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_DUTIES_LOW  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE_DUTIES_HIGH = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_SETTINGS    = 3'd7;

endpackage
`default_nettype wire

[sv/fan_speed_curve_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_curve_controller
// Chooses a fan duty, or firmware automatic control, once per control tick.
// ----------------------------------------------------------------------------
// One item per clock cycle is accepted while the output is not stalled, and one
// result item per input item is returned via the input and result registers.
// The rate is set by the held duty: each item reads the duty left by the item
// before it, and the single combinational stage between the input register and
// the result register computes both the result and the new held duty, so
// consecutive items follow each other without a gap. The output register
// decouples the sides: a new item can enter an empty input register while a
// result waits. Configuration must only be written while no item is in flight.
module fan_speed_curve_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fscc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fscc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] temperature, [23:8] fan_rpm
    input  wire logic [fscc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] target_duty, [8] apply_duty, [9] apply_auto, [15:10] zero
    output logic [fscc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import fscc_pkg::*;

    // Configuration registers.
    logic [2:0]  control_mode_reg;
    pct_t        static_duty_reg;
    logic [29:0] step_params_reg;
    logic [39:0] curve_temps_low_reg;
    logic [39:0] curve_temps_high_reg;
    logic [34:0] curve_duties_low_reg;
    logic [34:0] curve_duties_high_reg;
    logic [14:0] limit_settings_reg;

    // Pipeline and state.
    logic              in_valid_reg;
    temp_t             temperature_reg;
    logic [RPM_W-1:0]  fan_rpm_reg;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    duty_t             held_duty_reg;
    duty_t             held_duty_next;
    logic              auto_active_reg;
    logic              auto_active_next;

    logic advance;

    // Decoded fields.
    temp_t step_hi;
    temp_t step_lo;
    pct_t  step_floor;
    pct_t  step_size;
    pct_t  safe_min;
    logic  limit_en;
    pct_t  limit_duty;

    temp_t curve_temp [CURVE_POINTS];
    pct_t  curve_duty [CURVE_POINTS];

    logic signed [STEP_SUM_W-1:0] step_sum;
    logic signed [STEP_SUM_W-1:0] step_max;
    pct_t  step_result;
    pct_t  curve_sel;
    pct_t  curve_result;
    duty_t base_target;
    duty_t target;
    logic  limited_mode;
    logic  is_auto;
    logic  apply_duty;
    logic  apply_auto;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign step_hi    = step_params_reg[29:22];
    assign step_lo    = step_params_reg[21:14];
    assign step_floor = step_params_reg[13:7];
    assign step_size  = step_params_reg[6:0];
    assign safe_min   = limit_settings_reg[14:8];
    assign limit_en   = limit_settings_reg[7];
    assign limit_duty = limit_settings_reg[6:0];

    // Unpack curve points; points past the two register banks read as zero.
    always_comb
    begin
        for (int i = 0; i < CURVE_POINTS; i++)
        begin
            if (i < POINTS_PER_REG)
            begin
                curve_temp[i] = curve_temps_low_reg[TEMP_W*i +: TEMP_W];
                curve_duty[i] = curve_duties_low_reg[PCT_W*i +: PCT_W];
            end
            else if (i < 2*POINTS_PER_REG)
            begin
                curve_temp[i] = curve_temps_high_reg[TEMP_W*(i-POINTS_PER_REG) +: TEMP_W];
                curve_duty[i] = curve_duties_high_reg[PCT_W*(i-POINTS_PER_REG) +: PCT_W];
            end
            else
            begin
                curve_temp[i] = '0;
                curve_duty[i] = '0;
            end
        end
    end

    // Hysteresis step: the held duty may be the automatic code, so the sum is signed.
    always_comb
    begin
        step_sum = STEP_SUM_W'(held_duty_reg);
        if (temperature_reg > step_hi)
            step_sum = STEP_SUM_W'(held_duty_reg) + $signed({3'b000, step_size});
        else if (temperature_reg < step_lo)
            step_sum = STEP_SUM_W'(held_duty_reg) - $signed({3'b000, step_size});
        step_max = step_sum;
        if (step_max < $signed({3'b000, safe_min}))
            step_max = $signed({3'b000, safe_min});
        if (step_max < $signed({3'b000, step_floor}))
            step_max = $signed({3'b000, step_floor});
        if (step_max > $signed({3'b000, MAX_DUTY}))
            step_result = MAX_DUTY;
        else
            step_result = step_max[PCT_W-1:0];
    end

    // Curve: lowest matching interval wins; first duty below point 0, else last.
    always_comb
    begin
        curve_sel = curve_duty[CURVE_POINTS-1];
        for (int i = CURVE_POINTS - 2; i >= 0; i--)
        begin
            if (temperature_reg >= curve_temp[i] && temperature_reg < curve_temp[i+1])
                curve_sel = curve_duty[i];
        end
        if (temperature_reg < curve_temp[0])
            curve_sel = curve_duty[0];
        if (curve_sel < safe_min)
            curve_sel = safe_min;
        curve_result = (curve_sel > MAX_DUTY) ? MAX_DUTY : curve_sel;
    end

    always_comb
    begin
        limited_mode = 1'b1;
        unique case (control_mode_reg)
            MODE_AUTO:
            begin
                base_target  = AUTO_DUTY;
                limited_mode = 1'b0;
            end
            MODE_MAX:
            begin
                base_target  = duty_t'({1'b0, MAX_DUTY});
                limited_mode = 1'b0;
            end
            MODE_STATIC:
            begin
                base_target  = duty_t'({1'b0, static_duty_reg});
                limited_mode = 1'b0;
            end
            MODE_STEP:   base_target = duty_t'({1'b0, step_result});
            MODE_CURVE:  base_target = duty_t'({1'b0, curve_result});
            // Hold, and the undefined codes, keep the held duty, subject to the limit.
            default:     base_target = held_duty_reg;
        endcase

        target = base_target;
        if (limited_mode && limit_en && base_target > $signed({1'b0, limit_duty}))
            target = duty_t'({1'b0, limit_duty});

        is_auto          = (target == AUTO_DUTY);
        apply_auto       = is_auto && !auto_active_reg;
        apply_duty       = !is_auto && (held_duty_reg != target);
        auto_active_next = is_auto;
        held_duty_next   = is_auto ? AUTO_DUTY : target;
        // A stopped fan clears the held duty once the result is formed.
        if (fan_rpm_reg == '0)
            held_duty_next = '0;

        out_data_next = {6'b000000, apply_auto, apply_duty, target};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg      <= MODE_AUTO;
            static_duty_reg       <= 7'd50;
            step_params_reg       <= '0;
            curve_temps_low_reg   <= '0;
            curve_temps_high_reg  <= '0;
            curve_duties_low_reg  <= '0;
            curve_duties_high_reg <= '0;
            limit_settings_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_CONTROL_MODE:      control_mode_reg      <= cfg_wdata[2:0];
                REG_STATIC_DUTY:       static_duty_reg       <= cfg_wdata[PCT_W-1:0];
                REG_STEP_PARAMS:       step_params_reg       <= cfg_wdata[29:0];
                REG_CURVE_TEMPS_LOW:   curve_temps_low_reg   <= cfg_wdata[39:0];
                REG_CURVE_TEMPS_HIGH:  curve_temps_high_reg  <= cfg_wdata[39:0];
                REG_CURVE_DUTIES_LOW:  curve_duties_low_reg  <= cfg_wdata[34:0];
                REG_CURVE_DUTIES_HIGH: curve_duties_high_reg <= cfg_wdata[34:0];
                REG_LIMIT_SETTINGS:    limit_settings_reg    <= cfg_wdata[14:0];
                default:               control_mode_reg      <= control_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            held_duty_reg   <= '0;
            auto_active_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                held_duty_reg   <= held_duty_next;
                auto_active_reg <= auto_active_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            temperature_reg <= s_axis_tdata[7:0];
            fan_rpm_reg     <= s_axis_tdata[23:8];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    // A result never asks for both a duty write and a switch to automatic control.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("apply_duty and apply_auto both set");

    // Entering automatic control always carries the automatic code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tdata[7:0] == AUTO_DUTY))
        else $error("apply_auto without automatic target");

    // After an automatic result the held duty is the automatic code or zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_auto) |=> (auto_active_reg &&
            (held_duty_reg == AUTO_DUTY || held_duty_reg == '0)))
        else $error("state not updated for automatic control");

    // A stalled result must not be overwritten by a new one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

[verif/fan_speed_curve_controller_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_duty_checker
// Watches the configuration port and both streams of the fan speed curve
// controller, keeps its own copy of the registers, the held duty and the
// automatic-control flag, predicts one result per accepted item and compares
// every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module fan_duty_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fscc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fscc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    // [7:0] temperature, [23:8] fan_rpm
    input  wire logic [fscc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] target_duty, [8] apply_duty, [9] apply_auto, [15:10] zero
    input  wire logic [fscc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output int                                   fails,
    output int                                   outstanding,
    output int                                   checked
);
    import fscc_pkg::*;

    typedef struct packed {
        duty_t duty;
        logic  apply_d;
        logic  apply_a;
    } fan_result_t;

    // Mirror of the configuration registers.
    logic [2:0]  mode_reg;
    logic [6:0]  static_reg;
    logic [29:0] step_reg;
    logic [39:0] temps_lo_reg;
    logic [39:0] temps_hi_reg;
    logic [34:0] duties_lo_reg;
    logic [34:0] duties_hi_reg;
    logic [14:0] limit_reg;

    int          held;
    bit          auto_on;
    fan_result_t duty_q[$];
    fan_result_t want;
    logic [OUT_DATA_W-1:0] got;

    initial
    begin
        fails       = 0;
        outstanding = 0;
        checked     = 0;
    end

    function automatic int point_temp(int i);
        if (i < POINTS_PER_REG)
            return int'((temps_lo_reg >> (TEMP_W * i)) & 40'hFF);
        else if (i < 2 * POINTS_PER_REG)
            return int'((temps_hi_reg >> (TEMP_W * (i - POINTS_PER_REG))) & 40'hFF);
        return 0;
    endfunction

    function automatic int point_duty(int i);
        if (i < POINTS_PER_REG)
            return int'((duties_lo_reg >> (PCT_W * i)) & 35'h7F);
        else if (i < 2 * POINTS_PER_REG)
            return int'((duties_hi_reg >> (PCT_W * (i - POINTS_PER_REG))) & 35'h7F);
        return 0;
    endfunction

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    task automatic predict_tick(input temp_t t, input logic [RPM_W-1:0] rpm);
        int          safe_min;
        int          target;
        int          i;
        int          tc;
        fan_result_t res;
        safe_min    = int'(limit_reg[14:8]);
        tc          = int'(t);
        res.apply_d = 1'b0;
        res.apply_a = 1'b0;
        case (mode_reg)
            MODE_AUTO:   target = int'(AUTO_DUTY);
            MODE_MAX:    target = int'(MAX_DUTY);
            MODE_STATIC: target = int'(static_reg);
            default:
            begin
                // Hold, and the two undefined codes, start from the held duty.
                target = held;
                if (mode_reg == MODE_STEP)
                begin
                    if (tc > int'(step_reg[29:22]))
                        target = target + int'(step_reg[6:0]);
                    else if (tc < int'(step_reg[21:14]))
                        target = target - int'(step_reg[6:0]);
                    target = imax(imax(target, safe_min), int'(step_reg[13:7]));
                    target = imin(target, int'(MAX_DUTY));
                end
                else if (mode_reg == MODE_CURVE)
                begin
                    target = point_duty(0);
                    if (tc >= point_temp(0))
                    begin
                        for (i = 0; i < CURVE_POINTS; i++)
                        begin
                            if (i == CURVE_POINTS - 1)
                                target = point_duty(CURVE_POINTS - 1);
                            else if (tc >= point_temp(i) && tc < point_temp(i + 1))
                            begin
                                target = point_duty(i);
                                break;
                            end
                        end
                    end
                    target = imin(imax(target, safe_min), int'(MAX_DUTY));
                end
                if (limit_reg[7])
                    target = imin(target, int'(limit_reg[6:0]));
            end
        endcase

        if (target == int'(AUTO_DUTY))
        begin
            held = int'(AUTO_DUTY);
            if (!auto_on)
            begin
                res.apply_a = 1'b1;
                auto_on     = 1'b1;
            end
        end
        else
        begin
            auto_on = 1'b0;
            if (held != target)
            begin
                res.apply_d = 1'b1;
                held        = target;
            end
        end

        // A stopped fan clears the held duty once the result is formed.
        if (rpm == '0)
            held = 0;

        res.duty = target[DUTY_W-1:0];
        duty_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      = MODE_AUTO;
            static_reg    = 7'd50;
            step_reg      = '0;
            temps_lo_reg  = '0;
            temps_hi_reg  = '0;
            duties_lo_reg = '0;
            duties_hi_reg = '0;
            limit_reg     = '0;
            held          = 0;
            auto_on       = 1'b0;
            duty_q.delete();
            outstanding   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_CONTROL_MODE:      mode_reg      = cfg_wdata[2:0];
                    REG_STATIC_DUTY:       static_reg    = cfg_wdata[6:0];
                    REG_STEP_PARAMS:       step_reg      = cfg_wdata[29:0];
                    REG_CURVE_TEMPS_LOW:   temps_lo_reg  = cfg_wdata[39:0];
                    REG_CURVE_TEMPS_HIGH:  temps_hi_reg  = cfg_wdata[39:0];
                    REG_CURVE_DUTIES_LOW:  duties_lo_reg = cfg_wdata[34:0];
                    REG_CURVE_DUTIES_HIGH: duties_hi_reg = cfg_wdata[34:0];
                    REG_LIMIT_SETTINGS:    limit_reg     = cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_tick(s_axis_tdata[7:0], s_axis_tdata[23:8]);

            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (duty_q.size() == 0)
                begin
                    $error("result item with no expectation waiting: tdata %h", got);
                    fails++;
                end
                else
                begin
                    want = duty_q.pop_front();
                    checked++;
                    if (got[7:0] !== want.duty)
                    begin
                        $error("target_duty: expected %0d, actual %0d",
                               want.duty, $signed(got[7:0]));
                        fails++;
                    end
                    if (got[8] !== want.apply_d)
                    begin
                        $error("apply_duty: expected %0d, actual %0d", want.apply_d, got[8]);
                        fails++;
                    end
                    if (got[9] !== want.apply_a)
                    begin
                        $error("apply_auto: expected %0d, actual %0d", want.apply_a, got[9]);
                        fails++;
                    end
                    if (got[15:10] !== '0)
                    begin
                        $error("padding: expected 0, actual %0d", got[15:10]);
                        fails++;
                    end
                end
            end
            outstanding = duty_q.size();
        end
    end

endmodule

[verif/fan_speed_curve_controller_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_speed_curve_controller_test
// Drives the fan speed curve controller through a directed opening and then
// random setting phases with random idling on both streams; a checker module
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module fan_speed_curve_controller_test;
    import fscc_pkg::*;

    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  ITEM_TARGET  = 1720;
    localparam int  W_MODE       = 3;
    localparam int  W_STATIC     = 7;
    localparam int  W_STEP       = 30;
    localparam int  W_TEMPS      = 40;
    localparam int  W_DUTIES     = 35;
    localparam int  W_LIMIT      = 15;
    // The two control mode codes the block leaves undefined.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef enum int {
        CURVE_RAMP,
        CURVE_SORTED,
        CURVE_SCRAMBLED,
        CURVE_FLAT_LOW,
        CURVE_FLAT_HIGH
    } curve_shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fails;
    int outstanding;
    int checked;
    int cycles;
    int sent;
    int phases;
    bit quiet;
    // Curve points and step thresholds, so temperatures can be aimed at edges.
    int aim_temps[12];

    fan_speed_curve_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fan_duty_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fails         (fails),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results still due.", outstanding);
            $display("fan_speed_curve_controller_test NOT OK");
            $finish;
        end
    end

    function automatic logic [29:0] step_word(int hi, int lo, int flr, int stp);
        return {hi[7:0], lo[7:0], flr[6:0], stp[6:0]};
    endfunction

    function automatic logic [14:0] limit_word(int safe_min, int en, int lim);
        return {safe_min[6:0], en[0], lim[6:0]};
    endfunction

    function automatic temp_t draw_temp();
        int r;
        int t;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        if (r <= 5)
        begin
            t = aim_temps[$urandom_range(0, 11)] + $urandom_range(0, 2) - 1;
            if (t < 0)
                t = 0;
            if (t > 255)
                t = 255;
            return t[7:0];
        end
        return temp_t'($urandom_range(0, 255));
    endfunction

    function automatic logic [RPM_W-1:0] draw_rpm();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 16'hFFFF;
        return RPM_W'($urandom_range(1, 65535));
    endfunction

    // Holds the sender off until every result has come and the pipe is empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val, input int width);
        logic [63:0] noise;
        wait_idle();
        noise = {$urandom, $urandom};
        // Now and then the bits above the register carry junk that must be dropped.
        if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
            val = val | (noise[CFG_DATA_W-1:0] << width);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input temp_t t, input logic [RPM_W-1:0] rpm);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rpm, t};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent++;
    endtask

    task automatic load_curve(input curve_shape_t shape);
        int          pts[10];
        int          dts[10];
        int          base;
        int          k;
        logic [39:0] tl;
        logic [39:0] th;
        logic [34:0] dl;
        logic [34:0] dh;
        base = $urandom_range(0, 80);
        for (k = 0; k < 10; k++)
        begin
            case (shape)
                CURVE_RAMP:
                begin
                    pts[k] = 10 * (k + 1);
                    dts[k] = 10 * k;
                end
                CURVE_SORTED:
                begin
                    pts[k] = base;
                    base   = base + $urandom_range(0, 25);
                    if (base > 255)
                        base = 255;
                end
                CURVE_SCRAMBLED: pts[k] = $urandom_range(0, 255);
                CURVE_FLAT_LOW:  pts[k] = 0;
                default:         pts[k] = 255;
            endcase
            if (shape != CURVE_RAMP)
                dts[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 100);
            aim_temps[k] = pts[k];
        end
        for (k = 0; k < 5; k++)
        begin
            tl[8*k +: 8] = pts[k][7:0];
            th[8*k +: 8] = pts[k+5][7:0];
            dl[7*k +: 7] = dts[k][6:0];
            dh[7*k +: 7] = dts[k+5][6:0];
        end
        write_reg(REG_CURVE_TEMPS_LOW, tl, W_TEMPS);
        write_reg(REG_CURVE_TEMPS_HIGH, th, W_TEMPS);
        write_reg(REG_CURVE_DUTIES_LOW, CFG_DATA_W'(dl), W_DUTIES);
        write_reg(REG_CURVE_DUTIES_HIGH, CFG_DATA_W'(dh), W_DUTIES);
    endtask

    task automatic set_step(input int hi, input int lo, input int flr, input int stp);
        aim_temps[10] = hi;
        aim_temps[11] = lo;
        write_reg(REG_STEP_PARAMS, CFG_DATA_W'(step_word(hi, lo, flr, stp)), W_STEP);
    endtask

    task automatic randomise_config(input bit all_regs);
        logic [2:0] mode;
        int         r;
        int         hi;
        int         lo;
        if (all_regs || $urandom_range(0, 2) == 0)
        begin
            r = $urandom_range(0, 3);
            write_reg(REG_STATIC_DUTY,
                      CFG_DATA_W'((r == 0) ? 0 : (r == 1) ? 100 : (r == 2) ? 127
                                  : $urandom_range(0, 127)), W_STATIC);
        end
        if (all_regs || $urandom_range(0, 2) == 0)
        begin
            hi = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
            lo = ($urandom_range(0, 7) == 0) ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255);
            set_step(hi, lo,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 40),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20));
        end
        if (all_regs || $urandom_range(0, 2) == 0)
            load_curve(curve_shape_t'($urandom_range(1, 4)));
        if (all_regs || $urandom_range(0, 2) == 0)
            write_reg(REG_LIMIT_SETTINGS,
                      CFG_DATA_W'(limit_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                                         : $urandom_range(0, 30),
                                             $urandom_range(0, 1), $urandom_range(0, 127))),
                      W_LIMIT);
        // Step and curve get the larger share, as they hold most of the logic.
        case ($urandom_range(0, 11))
            0:       mode = MODE_AUTO;
            1:       mode = MODE_MAX;
            2:       mode = MODE_STATIC;
            3:       mode = MODE_HOLD;
            4:       mode = MODE_SPARE_A;
            5:       mode = MODE_SPARE_B;
            6, 7, 8: mode = MODE_STEP;
            default: mode = MODE_CURVE;
        endcase
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(mode), W_MODE);
    endtask

    // The result side stalls at random, independently of the sender.
    initial
    begin : result_sink
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int  n;
        bit  first;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_CONTROL_MODE;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        sent          = 0;
        phases        = 0;
        foreach (aim_temps[k])
            aim_temps[k] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Automatic control after reset: flagged once, then held.
        send_item(8'd0, 16'd1);
        send_item(8'd255, 16'hFFFF);
        // Hold mode keeps a held automatic duty; a stopped fan then clears it.
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_HOLD), W_MODE);
        send_item(8'd40, 16'd100);
        send_item(8'd40, 16'd0);
        send_item(8'd40, 16'd5);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_MAX), W_MODE);
        send_item(8'd25, 16'd1000);
        write_reg(REG_STATIC_DUTY, 127, W_STATIC);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_STATIC), W_MODE);
        send_item(8'd25, 16'd1000);
        write_reg(REG_STATIC_DUTY, 0, W_STATIC);
        send_item(8'd25, 16'd1000);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_SPARE_A), W_MODE);
        send_item(8'd128, 16'd7);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_SPARE_B), W_MODE);
        send_item(8'd128, 16'd7);

        // Step mode with a safe minimum and an enabled limit.
        set_step(50, 30, 10, 20);
        write_reg(REG_LIMIT_SETTINGS, CFG_DATA_W'(limit_word(20, 1, 60)), W_LIMIT);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_STEP), W_MODE);
        send_item(8'd255, 16'd300);
        send_item(8'd255, 16'd300);
        send_item(8'd255, 16'd300);
        send_item(8'd0, 16'd300);
        send_item(8'd40, 16'd300);
        send_item(8'd0, 16'd0);
        set_step(255, 255, 127, 127);
        send_item(8'd0, 16'd1);

        // Curve mode on an ascending ramp, then on a curve with every point temperature at zero.
        write_reg(REG_LIMIT_SETTINGS, CFG_DATA_W'(limit_word(0, 0, 0)), W_LIMIT);
        load_curve(CURVE_RAMP);
        write_reg(REG_CONTROL_MODE, CFG_DATA_W'(MODE_CURVE), W_MODE);
        send_item(8'd5, 16'd1);
        send_item(8'd10, 16'd1);
        send_item(8'd55, 16'd1);
        send_item(8'd100, 16'd1);
        send_item(8'd255, 16'd1);
        load_curve(CURVE_FLAT_LOW);
        send_item(8'd77, 16'd1);

        first = 1'b1;
        while (sent < ITEM_TARGET)
        begin
            randomise_config(first);
            first = 1'b0;
            quiet = ($urandom_range(0, 3) == 0);
            n     = $urandom_range(30, 70);
            repeat (n) send_item(draw_temp(), draw_rpm());
            phases++;
        end
        quiet = 1'b0;

        wait_idle();
        repeat (10) @(negedge clk);
        $display("Run covered %0d items: a directed opening and %0d random setting phases.",
                 sent, phases);
        $display("%0d result items were checked against the prediction.", checked);
        if (fails == 0 && outstanding == 0)
            $display("fan_speed_curve_controller_test OK");
        else
            $display("fan_speed_curve_controller_test NOT OK");
        $finish;
    end

endmodule
